// ----- design/morse_code_keyer_macros.svh -----
// ============================================================================
// Morse code keyer assertion macros
// Shared assertion forms, clocked on clk and held off while rst_n is low.
// ============================================================================
`ifndef MORSE_CODE_KEYER_MACROS_SVH
`define MORSE_CODE_KEYER_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define MCK_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold on the clock edge after the trigger.
`define MCK_ASSERT_NEXT(name, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mck_pkg.sv -----
// ============================================================================
// Morse code keyer package
// Widths, register indexes, reset timings, command type and symbol tables.
// ============================================================================
package mck_pkg;

    // Field widths.
    localparam int CHAR_W   = 8;
    localparam int DUR_W    = 16;
    localparam int LEN_W    = 3;
    localparam int PAT_W    = 5;
    localparam int CFG_IDX_W = 3;

    // Default depth of the command queue between front and back end.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DOT         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_GAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LETTER_GAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP    = 3'd4;

    // Timing values after reset, in milliseconds.
    localparam logic [DUR_W-1:0] DOT_RESET         = 16'd200;
    localparam logic [DUR_W-1:0] DASH_RESET        = 16'd600;
    localparam logic [DUR_W-1:0] ELEMENT_GAP_RESET = 16'd200;
    localparam logic [DUR_W-1:0] LETTER_GAP_RESET  = 16'd600;
    localparam logic [DUR_W-1:0] WORD_GAP_RESET    = 16'd1400;

    // Character codes used for classification.
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    // Segment timings as handed to the back end.
    typedef struct packed {
        logic [DUR_W-1:0] dot;
        logic [DUR_W-1:0] dash;
        logic [DUR_W-1:0] element_gap;
        logic [DUR_W-1:0] letter_gap;
        logic [DUR_W-1:0] word_gap;
    } mck_timing_t;

    // Classified character. The pattern is left aligned: the first element
    // sits in the top bit, 1 for a dash and 0 for a dot.
    typedef struct packed {
        logic             word_gap;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pattern;
    } mck_cmd_t;

    // Letter table: element count in the top three bits, pattern below,
    // first element in the highest used bit.
    function automatic logic [7:0] letter_sym(input logic [4:0] idx);
        logic [7:0] sym;
        case (idx)
            5'd0:    sym = {3'd2, 5'h01};
            5'd1:    sym = {3'd4, 5'h08};
            5'd2:    sym = {3'd4, 5'h0A};
            5'd3:    sym = {3'd3, 5'h04};
            5'd4:    sym = {3'd1, 5'h00};
            5'd5:    sym = {3'd4, 5'h02};
            5'd6:    sym = {3'd3, 5'h06};
            5'd7:    sym = {3'd4, 5'h00};
            5'd8:    sym = {3'd2, 5'h00};
            5'd9:    sym = {3'd4, 5'h07};
            5'd10:   sym = {3'd3, 5'h05};
            5'd11:   sym = {3'd4, 5'h04};
            5'd12:   sym = {3'd2, 5'h03};
            5'd13:   sym = {3'd2, 5'h02};
            5'd14:   sym = {3'd3, 5'h07};
            5'd15:   sym = {3'd4, 5'h06};
            5'd16:   sym = {3'd4, 5'h0D};
            5'd17:   sym = {3'd3, 5'h02};
            5'd18:   sym = {3'd3, 5'h00};
            5'd19:   sym = {3'd1, 5'h01};
            5'd20:   sym = {3'd3, 5'h01};
            5'd21:   sym = {3'd4, 5'h01};
            5'd22:   sym = {3'd3, 5'h03};
            5'd23:   sym = {3'd4, 5'h09};
            5'd24:   sym = {3'd4, 5'h0B};
            5'd25:   sym = {3'd4, 5'h0C};
            default: sym = 8'h00;
        endcase
        return sym;
    endfunction

    // Digit table, same layout; every digit has five elements.
    function automatic logic [7:0] digit_sym(input logic [3:0] idx);
        logic [7:0] sym;
        case (idx)
            4'd0:    sym = {3'd5, 5'h1F};
            4'd1:    sym = {3'd5, 5'h0F};
            4'd2:    sym = {3'd5, 5'h07};
            4'd3:    sym = {3'd5, 5'h03};
            4'd4:    sym = {3'd5, 5'h01};
            4'd5:    sym = {3'd5, 5'h00};
            4'd6:    sym = {3'd5, 5'h10};
            4'd7:    sym = {3'd5, 5'h18};
            4'd8:    sym = {3'd5, 5'h1C};
            4'd9:    sym = {3'd5, 5'h1E};
            default: sym = 8'h00;
        endcase
        return sym;
    endfunction

    // Turns a character code into a command for the back end.
    function automatic mck_cmd_t classify(input logic [CHAR_W-1:0] code);
        mck_cmd_t          cmd;
        logic [7:0]        sym;
        logic [CHAR_W-1:0] offs;
        logic [LEN_W-1:0]  len;
        logic [PAT_W-1:0]  pat;
        cmd  = '0;
        sym  = 8'h00;
        offs = '0;
        if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
            offs = code - CHAR_UPPER_A;
            sym  = letter_sym(offs[4:0]);
        end else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
            offs = code - CHAR_LOWER_A;
            sym  = letter_sym(offs[4:0]);
        end else if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            offs = code - CHAR_ZERO;
            sym  = digit_sym(offs[3:0]);
        end else if (code == CHAR_SPACE) begin
            cmd.word_gap = 1'b1;
        end
        len = sym[7:5];
        pat = sym[4:0];
        cmd.len     = len;
        cmd.pattern = PAT_W'(pat << (LEN_W'(PAT_W) - len));
        return cmd;
    endfunction

endpackage

// ----- design/mck_front.sv -----
// ============================================================================
// Morse code keyer front end
// Accepts character items, classifies them and holds one command for the queue.
// ============================================================================
module mck_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       char_valid,
    output logic                       char_stall,
    input  logic [mck_pkg::CHAR_W-1:0] char_code,
    input  logic                       q_full,
    output logic                       q_push,
    output mck_pkg::mck_cmd_t          q_data
);

    logic              front_valid_reg;
    logic              front_valid_next;
    mck_pkg::mck_cmd_t cmd_reg;
    logic              accept;

    // The held command moves on whenever the queue has room.
    assign q_push     = front_valid_reg && !q_full;
    assign q_data     = cmd_reg;
    assign char_stall = front_valid_reg && q_full;
    assign accept     = char_valid && !char_stall;

    // Occupancy of the classification stage.
    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    // Classified command, captured with each accepted item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= mck_pkg::classify(char_code);
        end
    end

endmodule

// ----- design/mck_queue.sv -----
// ============================================================================
// Morse code keyer command queue
// Small first-in first-out store that decouples front and back end.
// ============================================================================
module mck_queue
#(
    parameter int DEPTH = mck_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mck_pkg::mck_cmd_t push_data,
    input  logic              pop,
    output mck_pkg::mck_cmd_t head,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mck_pkg::mck_cmd_t mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/mck_back.sv -----
// ============================================================================
// Morse code keyer back end
// Sequencer that walks one command and emits one segment item per clock while the output is not stalled.
// ============================================================================
module mck_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mck_pkg::mck_timing_t      timing,
    input  logic                      q_empty,
    input  mck_pkg::mck_cmd_t         q_head,
    output logic                      q_pop,
    output logic                      seg_valid,
    input  logic                      seg_stall,
    output logic                      led_on,
    output logic [mck_pkg::DUR_W-1:0] duration_ms,
    output logic                      last_segment
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WORD   = 5'b00010,
        ST_MARK   = 5'b00100,
        ST_SPACE  = 5'b01000,
        ST_LETTER = 5'b10000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [mck_pkg::PAT_W-1:0]      pattern_reg;
    logic [mck_pkg::PAT_W-1:0]      pattern_next;
    logic [mck_pkg::LEN_W-1:0]      count_reg;
    logic [mck_pkg::LEN_W-1:0]      count_next;
    logic                           seg_valid_reg;
    logic                           seg_valid_next;
    logic                           led_on_reg;
    logic                           led_on_next;
    logic [mck_pkg::DUR_W-1:0]      duration_reg;
    logic [mck_pkg::DUR_W-1:0]      duration_next;
    logic                           last_reg;
    logic                           last_next;
    logic                           out_free;
    logic                           emit;
    logic                           load;

    assign out_free     = !seg_valid_reg || !seg_stall;
    assign seg_valid    = seg_valid_reg;
    assign led_on       = led_on_reg;
    assign duration_ms  = duration_reg;
    assign last_segment = last_reg;

    // Segment sequencing: optional word gap, mark and space per element,
    // then the letter gap, which also picks up the next command.
    always_comb
    begin
        state_next    = state_reg;
        pattern_next  = pattern_reg;
        count_next    = count_reg;
        led_on_next   = led_on_reg;
        duration_next = duration_reg;
        last_next     = last_reg;
        emit          = 1'b0;
        load          = 1'b0;
        q_pop         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    load = 1'b1;
                end
            end
            ST_WORD:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    led_on_next   = 1'b0;
                    duration_next = timing.word_gap;
                    last_next     = 1'b0;
                    state_next    = (count_reg == '0) ? ST_LETTER : ST_MARK;
                end
            end
            ST_MARK:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    led_on_next   = 1'b1;
                    duration_next = pattern_reg[mck_pkg::PAT_W-1] ? timing.dash : timing.dot;
                    last_next     = 1'b0;
                    state_next    = ST_SPACE;
                end
            end
            ST_SPACE:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    led_on_next   = 1'b0;
                    duration_next = timing.element_gap;
                    last_next     = 1'b0;
                    pattern_next  = {pattern_reg[mck_pkg::PAT_W-2:0], 1'b0};
                    count_next    = count_reg - 1'b1;
                    state_next    = (count_reg == mck_pkg::LEN_W'(1)) ? ST_LETTER : ST_MARK;
                end
            end
            ST_LETTER:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    led_on_next   = 1'b0;
                    duration_next = timing.letter_gap;
                    last_next     = 1'b1;
                    if (!q_empty)
                    begin
                        load = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Taking a new command from the queue.
        if (load)
        begin
            q_pop        = 1'b1;
            pattern_next = q_head.pattern;
            count_next   = q_head.len;
            if (q_head.word_gap)
            begin
                state_next = ST_WORD;
            end
            else if (q_head.len != '0)
            begin
                state_next = ST_MARK;
            end
            else
            begin
                state_next = ST_LETTER;
            end
        end

        // Output register: a new segment replaces one that has been taken.
        if (emit)
        begin
            seg_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            seg_valid_next = 1'b0;
        end
        else
        begin
            seg_valid_next = seg_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            seg_valid_reg <= seg_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pattern_reg  <= pattern_next;
        led_on_reg   <= led_on_next;
        duration_reg <= duration_next;
        last_reg     <= last_next;
    end

endmodule

// ----- design/morse_code_keyer.sv -----
// ============================================================================
// Morse code keyer
// Turns character items into timed LED segment items in International Morse.
// ============================================================================
// Each accepted character yields one to eleven segment items: a space gives a
// word gap and the letter gap, a letter or digit gives a mark and an element
// gap per dot or dash and then the letter gap, any other code the letter gap
// alone. The back-end sequencer emits one segment per clock while the output
// is not stalled. The front end registers the classified command of each
// character, and a queue of QUEUE_DEPTH commands lets new characters be taken
// while earlier ones are still being keyed. Timing registers are written
// through the configuration port, which is always ready; writes should only
// be made while no character is in flight.
module morse_code_keyer
#(
    parameter int QUEUE_DEPTH = mck_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          char_valid,
    output logic                          char_stall,
    input  logic [mck_pkg::CHAR_W-1:0]    char_code,
    output logic                          seg_valid,
    input  logic                          seg_stall,
    output logic                          led_on,
    output logic [mck_pkg::DUR_W-1:0]     duration_ms,
    output logic                          last_segment,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mck_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mck_pkg::DUR_W-1:0]     cfg_data
);

    mck_pkg::mck_timing_t timing_reg;
    mck_pkg::mck_cmd_t    push_data;
    mck_pkg::mck_cmd_t    q_head;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;

    assign cfg_ready = 1'b1;

    // Timing registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.dot         <= mck_pkg::DOT_RESET;
            timing_reg.dash        <= mck_pkg::DASH_RESET;
            timing_reg.element_gap <= mck_pkg::ELEMENT_GAP_RESET;
            timing_reg.letter_gap  <= mck_pkg::LETTER_GAP_RESET;
            timing_reg.word_gap    <= mck_pkg::WORD_GAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mck_pkg::CFG_DOT:         timing_reg.dot         <= cfg_data;
                mck_pkg::CFG_DASH:        timing_reg.dash        <= cfg_data;
                mck_pkg::CFG_ELEMENT_GAP: timing_reg.element_gap <= cfg_data;
                mck_pkg::CFG_LETTER_GAP:  timing_reg.letter_gap  <= cfg_data;
                mck_pkg::CFG_WORD_GAP:    timing_reg.word_gap    <= cfg_data;
                default:                  timing_reg             <= timing_reg;
            endcase
        end
    end

    // Classification of incoming characters.
    mck_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (push_data)
    );

    // Command queue between the two halves.
    mck_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Segment sequencer and output register.
    mck_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .timing       (timing_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .seg_valid    (seg_valid),
        .seg_stall    (seg_stall),
        .led_on       (led_on),
        .duration_ms  (duration_ms),
        .last_segment (last_segment)
    );

endmodule

// ----- design/mck_checker.sv -----
// ============================================================================
// Morse code keyer checker
// Port-level assertions on the character and segment streams, bound to the
// top level.
// ============================================================================
`include "morse_code_keyer_macros.svh"

module mck_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          char_valid,
    input logic                          char_stall,
    input logic [mck_pkg::CHAR_W-1:0]    char_code,
    input logic                          seg_valid,
    input logic                          seg_stall,
    input logic                          led_on,
    input logic [mck_pkg::DUR_W-1:0]     duration_ms,
    input logic                          last_segment
);

    logic                        char_held;
    logic                        seg_held;
    logic                        seg_taken;
    logic                        seg_gap;
    logic [mck_pkg::DUR_W+1:0]   seg_payload;

    // Handshake conditions and the segment payload seen as one word.
    assign char_held   = char_valid && char_stall;
    assign seg_held    = seg_valid && seg_stall;
    assign seg_taken   = seg_valid && !seg_stall;
    assign seg_gap     = seg_valid && !led_on && !last_segment;
    assign seg_payload = {led_on, duration_ms, last_segment};

    // A stalled character item keeps its code.
    `MCK_ASSERT_NEXT(a_char_hold, char_held, char_valid && $stable(char_code), "stalled item changed")

    // A stalled segment item keeps its payload.
    `MCK_ASSERT_NEXT(a_seg_hold, seg_held, seg_valid && $stable(seg_payload), "stalled segment moved")

    // The closing segment of a character is always a dark gap.
    `MCK_ASSERT_ALWAYS(a_last_dark, !(seg_valid && last_segment && led_on), "last segment lit")

    // A lit segment is always followed directly by a dark element gap.
    `MCK_ASSERT_NEXT(a_mark_then_gap, seg_taken && led_on, seg_gap, "mark not followed by gap")

endmodule

bind morse_code_keyer mck_checker u_mck_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .seg_valid    (seg_valid),
    .seg_stall    (seg_stall),
    .led_on       (led_on),
    .duration_ms  (duration_ms),
    .last_segment (last_segment)
);
